>>> hw/rtl/bsp_pkg.sv
// Shared types and constants for the bounded stack with purge.
// Used by the controller, datapath and top level; depends on nothing.
package bsp_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_OUT_W  = 5;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_PURGE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    func_e                      func;
    logic signed [VALUE_W-1:0]  value;
  } in_t;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  popped_value;
    logic [COUNT_OUT_W-1:0]     entry_count;
    logic                       is_full_flag;
    logic                       is_empty_flag;
  } out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    push_wr;
    logic    pop_rd;
    logic    clear;
    logic    purge_init;
    logic    purge_run;
    logic    purge_fin;
    logic    load_out;
    logic    pop_sel;
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic purge_done;
  } stat_t;

endpackage

>>> hw/rtl/bounded_stack_with_purge_top.sv
// Bounded LIFO stack with purge. Push, clear and a pop or push that fails
// answer in the cycle after acceptance, one item per cycle while results drain.
// A successful pop answers through the registered RAM read, then the result register.
// Purge walks the entry RAM one entry a cycle.
// Reset empties the stack and clears the result valid; RAM and result register contents are kept.
// Depends on bsp_pkg, bsp_ctrl, bsp_datapath and bsp_ram.
module bounded_stack_with_purge_top #(
  parameter int unsigned CAPACITY = bsp_pkg::DEF_CAPACITY
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bsp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bsp_pkg::out_t out_data_o
);
  import bsp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_data_i.func),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  bsp_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_value_i (in_data_i.value),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

>>> hw/rtl/bsp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependencies.
module bsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bsp_datapath.sv
// Stack datapath: entry RAM, depth count, purge pointers and result register.
// Depends on bsp_pkg and bsp_ram.
module bsp_datapath #(
  parameter int unsigned CAPACITY = bsp_pkg::DEF_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [bsp_pkg::VALUE_W-1:0]  in_value_i,
  input  bsp_pkg::cmd_t                       cmd_i,
  output bsp_pkg::stat_t                      stat_o,
  output bsp_pkg::out_t                       out_data_o
);
  import bsp_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      rd_q, rd_d;
  logic [CW-1:0]      wr_q, wr_d;
  logic               pend_q, pend_d;
  logic [VALUE_W-1:0] key_q;
  out_t               out_q;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;
  logic [CW-1:0]      count_dec;
  logic               purge_wr;
  logic [31:0]        count_ext;

  assign count_dec = count_q - CW'(1);
  assign purge_wr  = pend_q && (ram_rdata != key_q);

  // Steer the RAM ports and the next count and pointers
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = count_q[AW-1:0];
    ram_wdata = in_value_i;
    ram_raddr = count_dec[AW-1:0];
    count_d   = count_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    pend_d    = pend_q;
    if (cmd_i.push_wr) begin
      ram_we  = 1'b1;
      count_d = count_q + CW'(1);
    end
    if (cmd_i.pop_rd) begin
      ram_re  = 1'b1;
      count_d = count_dec;
    end
    if (cmd_i.clear) begin
      count_d = '0;
    end
    if (cmd_i.purge_init) begin
      rd_d   = '0;
      wr_d   = '0;
      pend_d = 1'b0;
    end
    if (cmd_i.purge_run) begin
      // Keep the entry read last cycle unless it matches the key
      ram_we    = purge_wr;
      ram_waddr = wr_q[AW-1:0];
      ram_wdata = ram_rdata;
      wr_d      = wr_q + CW'(purge_wr);
      // Fetch the next entry while any remain
      ram_re    = (rd_q != count_q);
      ram_raddr = rd_q[AW-1:0];
      rd_d      = (rd_q != count_q) ? rd_q + CW'(1) : rd_q;
      pend_d    = (rd_q != count_q);
    end
    if (cmd_i.purge_fin) begin
      count_d = wr_q;
    end
  end

  bsp_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold count and purge pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      pend_q  <= pend_d;
    end
  end

  // Latch the purge key
  always_ff @(posedge clk_i) begin
    if (cmd_i.purge_init) begin
      key_q <= in_value_i;
    end
  end

  assign count_ext = 32'(count_d);

  // Load the result register from the post-operation state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.status        <= cmd_i.status;
      out_q.popped_value  <= cmd_i.pop_sel ? ram_rdata : '0;
      out_q.entry_count   <= count_ext[COUNT_OUT_W-1:0];
      out_q.is_full_flag  <= (count_d == CAP);
      out_q.is_empty_flag <= (count_d == '0);
    end
  end

  assign out_data_o        = out_q;
  assign stat_o.full       = (count_q == CAP);
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.purge_done = !pend_q && (rd_q == count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP)
    else $error("stack count above capacity");

  a_purge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.purge_run |-> (wr_q <= rd_q) && (rd_q <= count_q))
    else $error("purge pointers out of order");

  a_purge_wr_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.purge_run && pend_q) |-> (wr_q < rd_q))
    else $error("purge write not behind read");

endmodule

>>> hw/rtl/bsp_ctrl.sv
// Stack controller: accepts requests, sequences pop reads and purge walks,
// and owns the result valid. Depends on bsp_pkg.
module bsp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  bsp_pkg::func_e  in_func_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bsp_pkg::cmd_t   cmd_o,
  input  bsp_pkg::stat_t  stat_i
);
  import bsp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PURGE = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       pop_q, pop_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Decode requests and step the sequencer
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    pop_d   = pop_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_func_i)
            FUNC_PUSH: begin
              cmd_o.push_wr  = !stat_i.full;
              cmd_o.status   = stat_i.full ? STATUS_FULL : STATUS_OK;
              cmd_o.load_out = 1'b1;
            end
            FUNC_POP: begin
              if (stat_i.empty) begin
                cmd_o.status   = STATUS_EMPTY;
                cmd_o.load_out = 1'b1;
              end else begin
                cmd_o.pop_rd = 1'b1;
                pop_d        = 1'b1;
                state_d      = ST_EMIT;
              end
            end
            FUNC_CLEAR: begin
              cmd_o.clear    = 1'b1;
              cmd_o.load_out = 1'b1;
            end
            default: begin
              cmd_o.purge_init = 1'b1;
              state_d          = ST_PURGE;
            end
          endcase
        end
      end
      ST_PURGE: begin
        if (stat_i.purge_done) begin
          cmd_o.purge_fin = 1'b1;
          pop_d           = 1'b0;
          state_d         = ST_EMIT;
        end else begin
          cmd_o.purge_run = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.pop_sel  = pop_q;
          cmd_o.status   = STATUS_OK;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Set valid on load, drop it once the item is taken
  assign out_valid_d = cmd_o.load_out ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pop_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pop_q       <= pop_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.load_out)
    else $error("result overwritten while stalled");

  a_purge_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PURGE) |=> (state_q == ST_PURGE) || (state_q == ST_EMIT))
    else $error("purge left without result");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input open while busy");

endmodule
